[src/fpe_pkg.sv]
package fpe_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam int ACC_W         = 68;
    localparam int NUM_PLANES    = 6;

    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_TEST = 1'b1;

    localparam logic [1:0] VERDICT_OUTSIDE   = 2'd0;
    localparam logic [1:0] VERDICT_INSIDE    = 2'd1;
    localparam logic [1:0] VERDICT_NOT_READY = 2'd2;

    localparam logic [4:0] LAST_ELEM = 5'd31;

    localparam logic signed [ACC_W-1:0] SAT_HI = ACC_W'(64'sh7fffffff);
    localparam logic signed [ACC_W-1:0] SAT_LO = ACC_W'(-64'sh80000000);

    typedef enum logic [4:0] {
        S_IDLE,
        S_CLIP_RD,
        S_CLIP_MUL,
        S_CLIP_ACC,
        S_PL_RD,
        S_PL_RAW,
        S_PL_SQ,
        S_PL_SQACC,
        S_PL_CHK,
        S_PL_SQW,
        S_PL_DGO,
        S_PL_DW,
        S_PL_ZERO,
        S_T_RD,
        S_T_USE,
        S_T_ACC,
        S_FIN
    } state_t;

    function automatic logic signed [31:0] sat32(input logic signed [ACC_W-1:0] v);
        logic signed [31:0] r;
        if (v > SAT_HI)
        begin
            r = 32'sh7fffffff;
        end
        else if (v < SAT_LO)
        begin
            r = -32'sh80000000;
        end
        else
        begin
            r = v[31:0];
        end
        return r;
    endfunction

    // column of clip paired with column 3: right, left, bottom, top, far, near
    function automatic logic [1:0] plane_col(input logic [2:0] p);
        logic [1:0] c;
        case (p)
            3'd0, 3'd1: c = 2'd0;
            3'd2, 3'd3: c = 2'd1;
            default:    c = 2'd2;
        endcase
        return c;
    endfunction

    function automatic logic plane_add(input logic [2:0] p);
        logic a;
        case (p)
            3'd1, 3'd2, 3'd5: a = 1'b1;
            default:          a = 1'b0;
        endcase
        return a;
    endfunction

endpackage

[src/fpe_mul.sv]
module fpe_mul
    import fpe_pkg::*;
(
    input  logic               clk,
    input  logic signed [31:0] a,
    input  logic signed [31:0] b,
    output logic signed [63:0] p
);

    logic signed [63:0] p_reg;

    always_ff @(posedge clk)
    begin
        p_reg <= 64'(a) * 64'(b);
    end

    assign p = p_reg;

endmodule

[src/fpe_sqrt.sv]
module fpe_sqrt
    import fpe_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [63:0] din,
    output logic        done,
    output logic [31:0] root
);

    localparam int STEPS = 32;
    localparam int CNT_W = $clog2(STEPS + 1);

    logic [63:0]      v_reg;
    logic [33:0]      rem_reg;
    logic [31:0]      root_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;

    logic [33:0] rem_sh;
    logic [33:0] trial;
    logic        fit;

    // two bits of the radicand per step
    assign rem_sh = {rem_reg[31:0], v_reg[63:62]};
    assign trial  = {root_reg, 2'b01};
    assign fit    = rem_sh >= trial;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(STEPS);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            v_reg    <= din;
            rem_reg  <= '0;
            root_reg <= '0;
        end
        else if (busy_reg)
        begin
            v_reg    <= {v_reg[61:0], 2'b00};
            rem_reg  <= fit ? rem_sh - trial : rem_sh;
            root_reg <= {root_reg[30:0], fit};
        end
    end

    assign done = done_reg;
    assign root = root_reg;

endmodule

[src/fpe_div.sv]
module fpe_div
    import fpe_pkg::*;
#(
    parameter int DVD_W = 32 + FRAC_BITS_DEF
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [DVD_W-1:0] dividend,
    input  logic [31:0]      divisor,
    output logic             done,
    output logic [DVD_W-1:0] quotient
);

    localparam int CNT_W = $clog2(DVD_W + 1);

    logic [DVD_W-1:0] quo_reg;
    logic [32:0]      rem_reg;
    logic [31:0]      dsr_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;

    logic [32:0] rem_sh;
    logic        fit;

    // restoring division, one quotient bit per cycle
    assign rem_sh = {rem_reg[31:0], quo_reg[DVD_W-1]};
    assign fit    = rem_sh >= {1'b0, dsr_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(DVD_W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dsr_reg <= divisor;
        end
        else if (busy_reg)
        begin
            quo_reg <= {quo_reg[DVD_W-2:0], fit};
            rem_reg <= fit ? rem_sh - {1'b0, dsr_reg} : rem_sh;
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

[src/frustum_plane_extract_and_cull.sv]
// channel  dir  handshake            word
// in       in   in_valid/in_ready    cmd, elem_index, elem_value, pos_x/y/z, radius
// out      out  out_valid/out_ready  verdict
//
// load word: written from idle; loading element 31 starts plane extraction, paced by
//   the shared multiplier, the 32-step square root and the bit-serial divider
// test word: up to six planes in turn on the shared multiplier, stopping at the first reject
// in_ready is low while a word is in work; a held result does not block loads
// rst_n clears the sequencer, the output register and the plane valid flag
module frustum_plane_extract_and_cull
    import fpe_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic               cmd,
    input  logic [4:0]         elem_index,
    input  logic signed [31:0] elem_value,
    input  logic signed [31:0] pos_x,
    input  logic signed [31:0] pos_y,
    input  logic signed [31:0] pos_z,
    input  logic [30:0]        radius,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [1:0]         verdict
);

    localparam int DVD_W = 32 + FRAC_BITS;

    state_t state_reg, state_next;

    logic [1:0] r_reg, c_reg, k_reg, i_reg;
    logic [2:0] p_reg;
    logic       planes_valid_reg;
    logic       out_valid_reg;
    logic [1:0] verdict_reg;
    logic [1:0] pend_reg;

    logic signed [ACC_W-1:0] acc_reg;
    logic [63:0]             sq_reg;
    logic [31:0]             len_reg;
    logic signed [31:0]      raw_reg [4];
    logic signed [31:0]      x_reg, y_reg, z_reg;
    logic [30:0]             rad_reg;

    logic signed [31:0] mtx_mem [32];
    logic signed [31:0] clp_mem [16];
    logic signed [31:0] pln_mem [24];
    logic signed [31:0] mtx_a_reg, mtx_b_reg, clp_a_reg, clp_b_reg, pln_reg;

    logic in_acc, out_free;
    logic mtx_we, clp_we, pln_we, sqrt_start, div_start;
    logic signed [31:0] mul_a, mul_b, mul_b_coord;
    logic signed [63:0] mul_p;
    logic sqrt_done, div_done;
    logic [31:0] sqrt_root;
    logic [DVD_W-1:0] div_q;

    logic signed [ACC_W-1:0] acc_sum, raw_sum, s_val, q_signed;
    logic signed [31:0]      raw_cur;
    logic [31:0]             raw_mag;
    logic signed [31:0]      pln_wdata;
    logic                    reject;
    logic                    clip_last;

    assign in_acc    = in_valid && in_ready;
    assign out_free  = !out_valid_reg || out_ready;
    assign clip_last = (r_reg == 2'd3) && (c_reg == 2'd3) && (k_reg == 2'd3);

    assign acc_sum = acc_reg + ACC_W'(mul_p >>> FRAC_BITS);
    assign raw_sum = plane_add(p_reg) ? ACC_W'(clp_a_reg) + ACC_W'(clp_b_reg)
                                      : ACC_W'(clp_a_reg) - ACC_W'(clp_b_reg);
    assign raw_cur = raw_reg[i_reg];
    assign raw_mag = raw_cur[31] ? 32'(-raw_cur) : 32'(raw_cur);
    assign q_signed = raw_cur[31] ? -signed'(ACC_W'(div_q)) : signed'(ACC_W'(div_q));
    assign pln_wdata = (state_reg == S_PL_ZERO) ? 32'sd0 : sat32(q_signed);
    assign s_val = acc_reg + (ACC_W'(pln_reg) <<< FRAC_BITS)
                 + (signed'(ACC_W'(rad_reg)) <<< FRAC_BITS);
    assign reject = s_val[ACC_W-1] || (s_val == '0);

    always_comb
    begin
        case (i_reg)
            2'd0:    mul_b_coord = x_reg;
            2'd1:    mul_b_coord = y_reg;
            default: mul_b_coord = z_reg;
        endcase
    end

    fpe_mul u_mul (
        .clk (clk),
        .a   (mul_a),
        .b   (mul_b),
        .p   (mul_p)
    );

    fpe_sqrt u_sqrt (
        .clk   (clk),
        .rst_n (rst_n),
        .start (sqrt_start),
        .din   (sq_reg),
        .done  (sqrt_done),
        .root  (sqrt_root)
    );

    fpe_div #(
        .DVD_W (DVD_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend ({raw_mag, {FRAC_BITS{1'b0}}}),
        .divisor  (len_reg),
        .done     (div_done),
        .quotient (div_q)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_acc)
                begin
                    if (cmd == CMD_TEST)
                    begin
                        state_next = planes_valid_reg ? S_T_RD : S_FIN;
                    end
                    else if (elem_index == LAST_ELEM)
                    begin
                        state_next = S_CLIP_RD;
                    end
                end
            end
            S_CLIP_RD:  state_next = S_CLIP_MUL;
            S_CLIP_MUL: state_next = S_CLIP_ACC;
            S_CLIP_ACC: state_next = clip_last ? S_PL_RD : S_CLIP_RD;
            S_PL_RD:    state_next = S_PL_RAW;
            S_PL_RAW:   state_next = (i_reg == 2'd3) ? S_PL_SQ : S_PL_RD;
            S_PL_SQ:    state_next = S_PL_SQACC;
            S_PL_SQACC: state_next = (i_reg == 2'd2) ? S_PL_CHK : S_PL_SQ;
            S_PL_CHK:   state_next = (sq_reg == '0) ? S_PL_ZERO : S_PL_SQW;
            S_PL_SQW:
            begin
                if (sqrt_done)
                begin
                    state_next = S_PL_DGO;
                end
            end
            S_PL_DGO:   state_next = S_PL_DW;
            S_PL_DW:
            begin
                if (div_done)
                begin
                    if (i_reg != 2'd3)
                    begin
                        state_next = S_PL_DGO;
                    end
                    else
                    begin
                        state_next = (p_reg == 3'(NUM_PLANES - 1)) ? S_IDLE : S_PL_RD;
                    end
                end
            end
            S_PL_ZERO:
            begin
                if (i_reg == 2'd3)
                begin
                    state_next = (p_reg == 3'(NUM_PLANES - 1)) ? S_IDLE : S_PL_RD;
                end
            end
            S_T_RD:     state_next = S_T_USE;
            S_T_USE:
            begin
                if (i_reg != 2'd3)
                begin
                    state_next = S_T_ACC;
                end
                else if (reject || (p_reg == 3'(NUM_PLANES - 1)))
                begin
                    state_next = S_FIN;
                end
                else
                begin
                    state_next = S_T_RD;
                end
            end
            S_T_ACC:    state_next = S_T_RD;
            S_FIN:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:    state_next = S_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb
    begin
        in_ready   = 1'b0;
        mtx_we     = 1'b0;
        clp_we     = 1'b0;
        pln_we     = 1'b0;
        sqrt_start = 1'b0;
        div_start  = 1'b0;
        mul_a      = mtx_a_reg;
        mul_b      = mtx_b_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                mtx_we   = in_valid && (cmd == CMD_LOAD);
            end
            S_CLIP_ACC: clp_we = (k_reg == 2'd3);
            S_PL_SQ:
            begin
                mul_a = raw_cur;
                mul_b = raw_cur;
            end
            S_PL_CHK:   sqrt_start = (sq_reg != '0);
            S_PL_DGO:   div_start = 1'b1;
            S_PL_DW:    pln_we = div_done;
            S_PL_ZERO:  pln_we = 1'b1;
            S_T_USE:
            begin
                mul_a = pln_reg;
                mul_b = mul_b_coord;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            r_reg            <= '0;
            c_reg            <= '0;
            k_reg            <= '0;
            i_reg            <= '0;
            p_reg            <= '0;
            planes_valid_reg <= 1'b0;
            out_valid_reg    <= 1'b0;
            verdict_reg      <= VERDICT_OUTSIDE;
        end
        else
        begin
            state_reg <= state_next;
            if ((state_reg == S_FIN) && out_free)
            begin
                out_valid_reg <= 1'b1;
                verdict_reg   <= pend_reg;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (in_acc)
                    begin
                        r_reg <= '0;
                        c_reg <= '0;
                        k_reg <= '0;
                        i_reg <= '0;
                        p_reg <= '0;
                    end
                end
                S_CLIP_ACC:
                begin
                    k_reg <= k_reg + 1'b1;
                    if (k_reg == 2'd3)
                    begin
                        c_reg <= c_reg + 1'b1;
                        if (c_reg == 2'd3)
                        begin
                            r_reg <= r_reg + 1'b1;
                        end
                    end
                end
                S_PL_RAW:   i_reg <= i_reg + 1'b1;
                S_PL_SQACC: i_reg <= (i_reg == 2'd2) ? 2'd0 : i_reg + 1'b1;
                S_PL_DW, S_PL_ZERO:
                begin
                    if (pln_we)
                    begin
                        i_reg <= i_reg + 1'b1;
                        if (i_reg == 2'd3)
                        begin
                            if (p_reg == 3'(NUM_PLANES - 1))
                            begin
                                p_reg            <= '0;
                                planes_valid_reg <= 1'b1;
                            end
                            else
                            begin
                                p_reg <= p_reg + 1'b1;
                            end
                        end
                    end
                end
                S_T_USE:
                begin
                    if ((i_reg == 2'd3) && !reject && (p_reg != 3'(NUM_PLANES - 1)))
                    begin
                        i_reg <= '0;
                        p_reg <= p_reg + 1'b1;
                    end
                end
                S_T_ACC:    i_reg <= i_reg + 1'b1;
                default:
                begin
                    i_reg <= i_reg;
                end
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                acc_reg  <= '0;
                pend_reg <= VERDICT_NOT_READY;
                x_reg    <= pos_x;
                y_reg    <= pos_y;
                z_reg    <= pos_z;
                rad_reg  <= radius;
            end
            S_CLIP_ACC: acc_reg <= (k_reg == 2'd3) ? '0 : acc_sum;
            S_PL_RAW:
            begin
                raw_reg[i_reg] <= sat32(raw_sum);
                if (i_reg == 2'd3)
                begin
                    sq_reg <= '0;
                end
            end
            S_PL_SQACC: sq_reg <= sq_reg + unsigned'(mul_p);
            S_PL_SQW:
            begin
                if (sqrt_done)
                begin
                    len_reg <= sqrt_root;
                end
            end
            S_T_USE:
            begin
                if (i_reg == 2'd3)
                begin
                    acc_reg  <= '0;
                    pend_reg <= reject ? VERDICT_OUTSIDE : VERDICT_INSIDE;
                end
            end
            S_T_ACC:    acc_reg <= acc_reg + ACC_W'(mul_p);
            default:
            begin
                acc_reg <= acc_reg;
            end
        endcase
    end

    // matrix, clip and plane stores
    always_ff @(posedge clk)
    begin
        if (mtx_we && in_ready)
        begin
            mtx_mem[elem_index] <= elem_value;
        end
        mtx_a_reg <= mtx_mem[{r_reg, k_reg}];
        mtx_b_reg <= mtx_mem[{1'b1, k_reg, c_reg}];
    end

    always_ff @(posedge clk)
    begin
        if (clp_we)
        begin
            clp_mem[{r_reg, c_reg}] <= sat32(acc_sum);
        end
        clp_a_reg <= clp_mem[{i_reg, 2'd3}];
        clp_b_reg <= clp_mem[{i_reg, plane_col(p_reg)}];
    end

    always_ff @(posedge clk)
    begin
        if (pln_we)
        begin
            pln_mem[{p_reg, i_reg}] <= pln_wdata;
        end
        pln_reg <= pln_mem[{p_reg, i_reg}];
    end

    assign out_valid = out_valid_reg;
    assign verdict   = verdict_reg;

endmodule

[src/fpe_chk.sv]
module fpe_chk
    import fpe_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_ready,
    input logic       cmd,
    input logic [4:0] elem_index,
    input logic       out_valid,
    input logic       out_ready,
    input logic [1:0] verdict
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(verdict))
        else $error("held result word changed");

    a_verdict_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (verdict == VERDICT_OUTSIDE) || (verdict == VERDICT_INSIDE)
                      || (verdict == VERDICT_NOT_READY))
        else $error("bad verdict code");

    a_test_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && (cmd == CMD_TEST) |=> !in_ready)
        else $error("ready during sphere test");

    a_load_quick: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && (cmd == CMD_LOAD) && (elem_index != LAST_ELEM)
        |=> in_ready)
        else $error("plain load stalled input");

    a_extract_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && (cmd == CMD_LOAD) && (elem_index == LAST_ELEM)
        |=> !in_ready)
        else $error("ready during plane extraction");

endmodule

bind frustum_plane_extract_and_cull fpe_chk u_fpe_chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .cmd        (cmd),
    .elem_index (elem_index),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .verdict    (verdict)
);

[verif/fpe_cull_checker.sv]
module fpe_cull_checker
    import fpe_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               in_ready,
    input  logic               cmd,
    input  logic [4:0]         elem_index,
    input  logic signed [31:0] elem_value,
    input  logic signed [31:0] pos_x,
    input  logic signed [31:0] pos_y,
    input  logic signed [31:0] pos_z,
    input  logic [30:0]        radius,
    input  logic               out_valid,
    input  logic               out_ready,
    input  logic [1:0]         verdict,
    output int                 fail_count,
    output int                 pending
);

    timeunit 1ns;
    timeprecision 1ps;

    logic signed [31:0] mat_elems [32];
    logic signed [31:0] plane_coef [24];
    logic               planes_ready;
    logic [1:0]         verdict_fifo [$];

    function automatic logic signed [31:0] clamp32(input logic signed [69:0] v);
        logic signed [31:0] r;
        if (v > 70'sh7fffffff)
        begin
            r = 32'sh7fffffff;
        end
        else if (v < -70'sh80000000)
        begin
            r = -32'sh80000000;
        end
        else
        begin
            r = v[31:0];
        end
        return r;
    endfunction

    function automatic logic [63:0] int_sqrt(input logic [63:0] v);
        logic [63:0] r;
        logic [63:0] b;
        r = 64'd0;
        b = 64'h4000_0000_0000_0000;
        while (b > v)
        begin
            b = b >> 2;
        end
        while (b != 0)
        begin
            if (v >= r + b)
            begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end
            else
            begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    // right, left, bottom, top, far, near: column 3 minus or plus column p/2 (plus for left, bottom and near)
    task automatic rebuild_planes();
        logic signed [31:0] clip [16];
        logic signed [31:0] raw [4];
        logic signed [69:0] acc;
        logic signed [63:0] prod;
        logic signed [69:0] wv;
        logic signed [69:0] ev;
        logic signed [63:0] sqr;
        logic [63:0]        sq;
        logic signed [69:0] num;
        logic signed [69:0] den;
        logic               add;
        for (int r = 0; r < 4; r++)
        begin
            for (int c = 0; c < 4; c++)
            begin
                acc = '0;
                for (int k = 0; k < 4; k++)
                begin
                    prod = mat_elems[r*4+k] * mat_elems[16+k*4+c];
                    acc = acc + (prod >>> FRAC_BITS);
                end
                clip[r*4+c] = clamp32(acc);
            end
        end
        for (int p = 0; p < 6; p++)
        begin
            add = (p == 1 || p == 2 || p == 5);
            sq = 64'd0;
            for (int i = 0; i < 4; i++)
            begin
                wv = clip[i*4+3];
                ev = clip[i*4+p/2];
                raw[i] = clamp32(add ? wv + ev : wv - ev);
            end
            for (int i = 0; i < 3; i++)
            begin
                sqr = raw[i] * raw[i];
                sq = sq + sqr;
            end
            for (int i = 0; i < 4; i++)
            begin
                if (sq == 0)
                begin
                    plane_coef[p*4+i] = '0;
                end
                else
                begin
                    num = raw[i];
                    num = num <<< FRAC_BITS;
                    den = $signed({6'b0, int_sqrt(sq)});
                    plane_coef[p*4+i] = clamp32(num / den);
                end
            end
        end
        planes_ready = 1'b1;
    endtask

    function automatic logic [1:0] sphere_verdict(input logic signed [31:0] x,
                                                  input logic signed [31:0] y,
                                                  input logic signed [31:0] z,
                                                  input logic [30:0] rad);
        logic signed [69:0] s;
        logic signed [69:0] dr;
        logic [1:0]         v;
        v = VERDICT_INSIDE;
        for (int p = 0; p < 6; p++)
        begin
            dr = plane_coef[p*4+3];
            dr = dr + $signed({39'b0, rad});
            s = plane_coef[p*4+0] * 70'(x) + plane_coef[p*4+1] * 70'(y)
                + plane_coef[p*4+2] * 70'(z) + (dr <<< FRAC_BITS);
            if (s <= 0)
            begin
                v = VERDICT_OUTSIDE;
            end
        end
        return v;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            planes_ready = 1'b0;
            fail_count   <= 0;
            pending      <= 0;
            verdict_fifo.delete();
            for (int i = 0; i < 24; i++)
            begin
                plane_coef[i] = '0;
            end
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (verdict_fifo.size() == 0)
                begin
                    if (fail_count < 10)
                    begin
                        $display("%0t: unexpected verdict word %0d", $realtime, verdict);
                    end
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    if (verdict !== verdict_fifo[0])
                    begin
                        if (fail_count < 10)
                        begin
                            $display("%0t: verdict mismatch expected %0d actual %0d",
                                     $realtime, verdict_fifo[0], verdict);
                        end
                        fail_count <= fail_count + 1;
                    end
                    void'(verdict_fifo.pop_front());
                end
            end
            if (in_valid && in_ready)
            begin
                if (cmd == CMD_LOAD)
                begin
                    mat_elems[elem_index] = elem_value;
                    if (elem_index == LAST_ELEM)
                    begin
                        rebuild_planes();
                    end
                end
                else if (!planes_ready)
                begin
                    verdict_fifo.push_back(VERDICT_NOT_READY);
                end
                else
                begin
                    verdict_fifo.push_back(sphere_verdict(pos_x, pos_y, pos_z, radius));
                end
            end
            pending <= verdict_fifo.size();
        end
    end

endmodule

[verif/frustum_plane_extract_and_cull_tb.sv]
module frustum_plane_extract_and_cull_tb
    import fpe_pkg::*;
;

    timeunit 1ns;
    timeprecision 1ps;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_ready;
    logic               cmd = CMD_LOAD;
    logic [4:0]         elem_index = '0;
    logic signed [31:0] elem_value = '0;
    logic signed [31:0] pos_x = '0;
    logic signed [31:0] pos_y = '0;
    logic signed [31:0] pos_z = '0;
    logic [30:0]        radius = '0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    logic [1:0]         verdict;
    int                 fail_count;
    int                 pending;
    int                 words_sent = 0;
    int                 burst_left = 0;

    frustum_plane_extract_and_cull uut
    (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready), .cmd(cmd),
        .elem_index(elem_index), .elem_value(elem_value), .pos_x(pos_x), .pos_y(pos_y),
        .pos_z(pos_z), .radius(radius), .out_valid(out_valid), .out_ready(out_ready),
        .verdict(verdict)
    );

    fpe_cull_checker chk
    (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready), .cmd(cmd),
        .elem_index(elem_index), .elem_value(elem_value), .pos_x(pos_x), .pos_y(pos_y),
        .pos_z(pos_z), .radius(radius), .out_valid(out_valid), .out_ready(out_ready),
        .verdict(verdict), .fail_count(fail_count), .pending(pending)
    );

    always #5 clk = ~clk;

    initial
    begin
        #20ms;
        $display("== FAIL ==");
        $finish;
    end

    // receiver stall pattern with one long hold-off
    initial
    begin
        int mode;
        int cyc;
        cyc = 0;
        mode = 0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            cyc++;
            if (cyc % 200 == 0)
            begin
                mode = $urandom_range(0, 2);
            end
            if (cyc >= 4000 && cyc < 4600)
            begin
                out_ready <= 1'b0;
            end
            else if (mode == 0)
            begin
                out_ready <= 1'b1;
            end
            else if (mode == 1)
            begin
                out_ready <= $urandom_range(0, 1);
            end
            else
            begin
                out_ready <= ($urandom_range(0, 3) == 0);
            end
        end
    end

    task automatic send_word(input logic c, input logic [4:0] idx, input logic [31:0] val,
                             input logic [31:0] x, input logic [31:0] y,
                             input logic [31:0] z, input logic [30:0] r);
        in_valid   <= 1'b1;
        cmd        <= c;
        elem_index <= idx;
        elem_value <= val;
        pos_x      <= x;
        pos_y      <= y;
        pos_z      <= z;
        radius     <= r;
        @(negedge clk);
        while (!in_ready)
        begin
            @(negedge clk);
        end
        @(posedge clk);
        words_sent++;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 40);
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
        end
        else
        begin
            burst_left--;
        end
    endtask

    task automatic load_word(input logic [4:0] idx, input logic [31:0] val);
        send_word(CMD_LOAD, idx, val, $urandom, $urandom, $urandom, 31'($urandom));
    endtask

    task automatic test_word(input logic [31:0] x, input logic [31:0] y,
                             input logic [31:0] z, input logic [30:0] r);
        send_word(CMD_TEST, 5'($urandom), $urandom, x, y, z, r);
    endtask

    function automatic logic [31:0] small_q(input int span);
        return $urandom_range(0, 2 * span) - span;
    endfunction

    function automatic logic [31:0] matrix_value(input int kind, input int idx);
        logic [31:0] v;
        case (kind)
            0: v = small_q(32'h40000);
            1:
            begin
                if (idx < 16)
                begin
                    v = (idx % 5 == 0) ? 32'h10000 : small_q(32'h8000);
                end
                else if (idx == 16 || idx == 21)
                begin
                    v = $urandom_range(32'h8000, 32'h20000);
                end
                else if (idx == 26)
                begin
                    v = -$urandom_range(32'h10000, 32'h18000);
                end
                else if (idx == 27)
                begin
                    v = 32'hffff0000;
                end
                else if (idx == 30)
                begin
                    v = -$urandom_range(32'h1000, 32'h30000);
                end
                else
                begin
                    v = small_q(32'h800);
                end
            end
            2: v = $urandom;
            3: v = '0;
            default: v = ($urandom_range(0, 1) != 0) ? 32'h7fffffff : 32'h80000000;
        endcase
        return v;
    endfunction

    task automatic load_matrices(input int kind);
        int order [31];
        int j;
        int t;
        for (int i = 0; i < 31; i++)
        begin
            order[i] = i;
        end
        for (int i = 30; i > 0; i--)
        begin
            j = $urandom_range(0, i);
            t = order[i];
            order[i] = order[j];
            order[j] = t;
        end
        for (int i = 0; i < 31; i++)
        begin
            load_word(5'(order[i]), matrix_value(kind, order[i]));
        end
        load_word(LAST_ELEM, matrix_value(kind, 31));
    endtask

    task automatic random_test();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick < 7)
        begin
            test_word(small_q(32'h80000), small_q(32'h80000), small_q(32'h80000),
                      ($urandom_range(0, 3) == 0) ? 31'd0
                                                  : 31'($urandom_range(0, 32'h30000)));
        end
        else
        begin
            test_word($urandom, $urandom, $urandom, 31'($urandom));
        end
    endtask

    initial
    begin
        int kind;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_word(32'h7fffffff, 32'h80000000, 32'h0, 31'h7fffffff);
        test_word(32'h80000000, 32'h7fffffff, 32'hffffffff, 31'd0);
        load_matrices(4);
        test_word(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 31'h7fffffff);
        test_word(32'h80000000, 32'h80000000, 32'h80000000, 31'd0);
        load_matrices(3);
        test_word('0, '0, '0, 31'd0);
        test_word('0, '0, '0, 31'd1);
        load_matrices(1);
        test_word('0, '0, 32'hfffe0000, 31'd0);
        test_word('0, '0, 32'h00200000, 31'h10000);
        // reload without element 31 keeps planes
        load_word(5'd0, 32'h0);
        test_word('0, '0, 32'hfffe0000, 31'd0);

        while (words_sent < 1950)
        begin
            kind = $urandom_range(0, 9);
            if (kind < 5)
            begin
                load_matrices(1);
            end
            else if (kind < 8)
            begin
                load_matrices(0);
            end
            else if (kind == 8)
            begin
                load_matrices(2);
            end
            else
            begin
                load_matrices($urandom_range(3, 4));
            end
            repeat ($urandom_range(10, 50))
            begin
                if ($urandom_range(0, 19) == 0)
                begin
                    load_word(5'($urandom_range(0, 30)), $urandom);
                end
                else
                begin
                    random_test();
                end
            end
        end

        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0 || out_valid)
        begin
            @(posedge clk);
        end
        repeat (100) @(posedge clk);
        if (fail_count == 0 && pending == 0)
        begin
            $display("== PASS ==");
        end
        else
        begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
